// ===== hdl/stcsc_pkg.sv =====
`timescale 1ns / 1ps
package stcsc_pkg;

    localparam int DEF_MAX_DIM     = 65536;
    localparam int DEF_MAX_ENTRIES = 1048576;

    localparam int DIM_W       = 17;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int N_SLOTS     = 4;

    localparam logic [DIM_W-1:0] SIZE_RESET = 17'h10000;

    // Register index, taken from paddr bit 2.
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_ROW_RANGE = 3'd0,
        ERR_COL_RANGE = 3'd1,
        ERR_COL_ORDER = 3'd2,
        ERR_ROW_ORDER = 3'd3,
        ERR_OVERFLOW  = 3'd4
    } t_err;

    typedef struct packed {
        logic [DIM_W-1:0]   row_in;
        logic [DIM_W-1:0]   col_in;
        logic signed [31:0] value_in;
        logic               last_in;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [19:0]        entry_position;
        logic [15:0]        entry_row;
        logic signed [31:0] entry_value;
        logic [DIM_W-1:0]   range_first;
        logic [DIM_W-1:0]   range_final;
        logic [20:0]        pointer_value;
        t_err               error_code;
        logic               last_out;
    } t_out;

    typedef struct packed {
        logic [DIM_W-1:0] matrix_rows;
        logic [DIM_W-1:0] matrix_cols;
    } t_cfg;

    // Up to four results of one item, in emission order, with a presence mask.
    typedef struct packed {
        logic [N_SLOTS-1:0] mask;
        t_out [N_SLOTS-1:0] res;
    } t_cmd;

endpackage

// ===== hdl/sorted_triplet_to_csc_builder_top.sv =====
`timescale 1ns / 1ps
// Path: an accepted item goes into the command queue, then the back end's slot registers, then the output register.
// Throughput: one item accepted per cycle while the 2-deep command queue has room; the output
// register delivers one result per cycle while pop is high, so an item holds it until all its results leave.
// Reset: i_rst_n is synchronous and active low; it empties the queue and output register,
// clears the run state and sets matrix_rows and matrix_cols to 65536.
module sorted_triplet_to_csc_builder_top #(
    parameter int MAX_DIM     = stcsc_pkg::DEF_MAX_DIM,
    parameter int MAX_ENTRIES = stcsc_pkg::DEF_MAX_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [stcsc_pkg::ADDR_W-1:0]    paddr,
    input  logic [stcsc_pkg::DATA_W-1:0]    pwdata,
    output logic [stcsc_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            push,
    output logic                            full,
    input  stcsc_pkg::t_in                  i_item,
    output logic                            empty,
    input  logic                            pop,
    output stcsc_pkg::t_out                 o_result
);

    localparam int DW = stcsc_pkg::DIM_W;

    logic [DW-1:0]   r_rows;
    logic [DW-1:0]   r_cols;
    stcsc_pkg::t_cfg cfg;
    logic            cfg_wr;

    logic            q_push, q_full, q_valid, q_pop;
    stcsc_pkg::t_cmd q_in, q_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= stcsc_pkg::SIZE_RESET;
            r_cols <= stcsc_pkg::SIZE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                stcsc_pkg::REG_ROWS: r_rows <= pwdata[DW-1:0];
                stcsc_pkg::REG_COLS: r_cols <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            stcsc_pkg::REG_ROWS: prdata = stcsc_pkg::DATA_W'(r_rows);
            stcsc_pkg::REG_COLS: prdata = stcsc_pkg::DATA_W'(r_cols);
            default:             prdata = '0;
        endcase
    end

    assign cfg.matrix_rows = r_rows;
    assign cfg.matrix_cols = r_cols;
    assign full            = q_full;

    stcsc_front #(
        .MAX_DIM     (MAX_DIM),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in)
    );

    stcsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_out)
    );

    stcsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

// ===== hdl/stcsc_front.sv =====
`timescale 1ns / 1ps
module stcsc_front #(
    parameter int MAX_DIM     = stcsc_pkg::DEF_MAX_DIM,
    parameter int MAX_ENTRIES = stcsc_pkg::DEF_MAX_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stcsc_pkg::t_cfg  i_cfg,
    input  logic             i_push,
    input  stcsc_pkg::t_in   i_item,
    input  logic             i_q_full,
    output logic             o_q_push,
    output stcsc_pkg::t_cmd  o_q_cmd
);

    localparam int DW   = stcsc_pkg::DIM_W;
    localparam int CntW = $clog2(MAX_ENTRIES + 1);

    logic [DW-1:0]   r_prev_row, n_prev_row;
    logic [DW-1:0]   r_prev_col, n_prev_col;
    logic            r_seen, n_seen;
    logic            r_held_v, n_held_v;
    logic [15:0]     r_held_row, n_held_row;
    logic [DW-1:0]   r_held_col, n_held_col;
    logic [31:0]     r_held_val, n_held_val;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [DW-1:0]   r_filled, n_filled;
    logic            r_err_seen, n_err_seen;

    logic            accept;
    logic [DW-1:0]   rows, cols;
    logic [DW-1:0]   row, col;
    logic [15:0]     row0;
    logic            nz, dup;
    logic            e_row, e_col, e_corder, e_rorder, e_ovf, any_err;
    logic [32:0]     sum;
    logic [31:0]     sat_sum;
    logic [DW-1:0]   close_first;
    stcsc_pkg::t_cmd cmd;

    assign accept = i_push && !i_q_full;
    assign rows   = (32'(i_cfg.matrix_rows) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : i_cfg.matrix_rows;
    assign cols   = (32'(i_cfg.matrix_cols) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : i_cfg.matrix_cols;
    assign row    = i_item.row_in;
    assign col    = i_item.col_in;
    assign row0   = 16'(row - DW'(1));
    assign nz     = (i_item.value_in != '0);

    assign e_row    = (row == '0) || (row > rows);
    assign e_col    = (col == '0) || (col > cols);
    assign e_corder = r_seen && (col < r_prev_col);
    assign e_rorder = r_seen && (col == r_prev_col) && (row < r_prev_row);
    assign dup      = r_held_v && (col == r_held_col) && (row0 == r_held_row);
    assign e_ovf    = nz && !dup && (r_cnt >= CntW'(MAX_ENTRIES));
    assign any_err  = e_row || e_col || e_corder || e_rorder || e_ovf;

    // Saturating Q16.16 sum for a repeated coordinate.
    assign sum = {r_held_val[31], r_held_val} + {i_item.value_in[31], i_item.value_in};
    assign sat_sum = (sum[32] != sum[31]) ? (sum[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                                          : sum[31:0];

    always_comb begin
        n_prev_row  = r_prev_row;
        n_prev_col  = r_prev_col;
        n_seen      = r_seen;
        n_held_v    = r_held_v;
        n_held_row  = r_held_row;
        n_held_col  = r_held_col;
        n_held_val  = r_held_val;
        n_cnt       = r_cnt;
        n_filled    = r_filled;
        n_err_seen  = r_err_seen;
        cmd         = '0;
        close_first = '0;

        if (r_err_seen) begin
            // Items are dropped until the closing item restarts the run.
            if (i_item.last_in) begin
                n_err_seen = 1'b0;
                n_prev_row = '0;
                n_prev_col = '0;
                n_seen     = 1'b0;
                n_held_v   = 1'b0;
                n_held_row = '0;
                n_held_col = '0;
                n_held_val = '0;
                n_cnt      = '0;
                n_filled   = '0;
            end
        end else if (any_err) begin
            cmd.mask[0]         = 1'b1;
            cmd.res[0].kind     = stcsc_pkg::KIND_ERROR;
            cmd.res[0].last_out = i_item.last_in;
            priority if (e_row) begin
                cmd.res[0].error_code = stcsc_pkg::ERR_ROW_RANGE;
            end else if (e_col) begin
                cmd.res[0].error_code = stcsc_pkg::ERR_COL_RANGE;
            end else if (e_corder) begin
                cmd.res[0].error_code = stcsc_pkg::ERR_COL_ORDER;
            end else if (e_rorder) begin
                cmd.res[0].error_code = stcsc_pkg::ERR_ROW_ORDER;
            end else begin
                cmd.res[0].error_code = stcsc_pkg::ERR_OVERFLOW;
            end
            n_held_v = 1'b0;
            if (i_item.last_in) begin
                n_prev_row = '0;
                n_prev_col = '0;
                n_seen     = 1'b0;
                n_held_row = '0;
                n_held_col = '0;
                n_held_val = '0;
                n_cnt      = '0;
                n_filled   = '0;
            end else begin
                n_err_seen = 1'b1;
            end
        end else begin
            n_prev_row = row;
            n_prev_col = col;
            n_seen     = 1'b1;
            if (nz && dup) begin
                n_held_val = sat_sum;
            end else if (nz) begin
                if (r_held_v) begin
                    cmd.mask[0]               = 1'b1;
                    cmd.res[0].kind           = stcsc_pkg::KIND_ENTRY;
                    cmd.res[0].entry_position = 20'(r_cnt - CntW'(1));
                    cmd.res[0].entry_row      = r_held_row;
                    cmd.res[0].entry_value    = r_held_val;
                end
                if (col > r_filled) begin
                    cmd.mask[1]              = 1'b1;
                    cmd.res[1].kind          = stcsc_pkg::KIND_FILL;
                    cmd.res[1].range_first   = r_filled;
                    cmd.res[1].range_final   = col - DW'(1);
                    cmd.res[1].pointer_value = 21'(r_cnt);
                    n_filled                 = col;
                end
                n_held_v   = 1'b1;
                n_held_row = row0;
                n_held_col = col;
                n_held_val = i_item.value_in;
                n_cnt      = r_cnt + CntW'(1);
            end

            if (i_item.last_in) begin
                if (n_held_v) begin
                    cmd.mask[2]               = 1'b1;
                    cmd.res[2].kind           = stcsc_pkg::KIND_ENTRY;
                    cmd.res[2].entry_position = 20'(n_cnt - CntW'(1));
                    cmd.res[2].entry_row      = n_held_row;
                    cmd.res[2].entry_value    = n_held_val;
                end
                close_first              = (n_filled < cols) ? n_filled : cols;
                cmd.mask[3]              = 1'b1;
                cmd.res[3].kind          = stcsc_pkg::KIND_FILL;
                cmd.res[3].range_first   = close_first;
                cmd.res[3].range_final   = cols;
                cmd.res[3].pointer_value = 21'(n_cnt);
                cmd.res[3].last_out      = 1'b1;
                n_prev_row = '0;
                n_prev_col = '0;
                n_seen     = 1'b0;
                n_held_v   = 1'b0;
                n_held_row = '0;
                n_held_col = '0;
                n_held_val = '0;
                n_cnt      = '0;
                n_filled   = '0;
            end
        end
    end

    assign o_q_push = accept && (cmd.mask != '0);
    assign o_q_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_row <= '0;
            r_prev_col <= '0;
            r_seen     <= 1'b0;
            r_held_v   <= 1'b0;
            r_held_row <= '0;
            r_held_col <= '0;
            r_held_val <= '0;
            r_cnt      <= '0;
            r_filled   <= '0;
            r_err_seen <= 1'b0;
        end else if (accept) begin
            r_prev_row <= n_prev_row;
            r_prev_col <= n_prev_col;
            r_seen     <= n_seen;
            r_held_v   <= n_held_v;
            r_held_row <= n_held_row;
            r_held_col <= n_held_col;
            r_held_val <= n_held_val;
            r_cnt      <= n_cnt;
            r_filled   <= n_filled;
            r_err_seen <= n_err_seen;
        end
    end

    a_no_push_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_seen |-> !o_q_push)
        else $error("result queued while items are being dropped");

    a_held_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_v |-> (r_cnt != '0))
        else $error("held entry without an allocated count");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_q_cmd.res[0].kind == stcsc_pkg::KIND_ERROR && o_q_cmd.mask[0])
        |-> (o_q_cmd.mask[3:1] == '0))
        else $error("error result shares an item with other results");

endmodule

// ===== hdl/stcsc_queue.sv =====
`timescale 1ns / 1ps
module stcsc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stcsc_pkg::t_cmd  i_cmd,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output stcsc_pkg::t_cmd  o_cmd
);

    localparam int Depth = stcsc_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    stcsc_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wp, n_wp;
    logic [PtrW-1:0] r_rp, n_rp;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == PtrW'(Depth - 1)) ? '0 : r_wp + PtrW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PtrW'(Depth - 1)) ? '0 : r_rp + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("item written into a full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("item read from an empty queue");

endmodule

// ===== hdl/stcsc_back.sv =====
`timescale 1ns / 1ps
module stcsc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  stcsc_pkg::t_cmd  i_q_cmd,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output stcsc_pkg::t_out  o_result
);

    localparam int NS = stcsc_pkg::N_SLOTS;

    stcsc_pkg::t_out [NS-1:0] r_cur, n_cur;
    logic [NS-1:0]            r_mask, n_mask;
    stcsc_pkg::t_out          r_out, n_out;
    logic                     r_out_v, n_out_v;

    logic                     out_free;
    logic                     take;
    logic [$clog2(NS)-1:0]    sel;
    logic [NS-1:0]            rem;

    assign out_free = !r_out_v || i_pop;
    assign take     = out_free && (r_mask != '0);

    // The lowest pending slot goes out first.
    always_comb begin
        sel = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = i[$clog2(NS)-1:0];
            end
        end
    end

    always_comb begin
        rem = r_mask;
        if (take) begin
            rem[sel] = 1'b0;
        end
    end

    assign o_q_pop = i_q_valid && (rem == '0);

    always_comb begin
        n_mask  = o_q_pop ? i_q_cmd.mask : rem;
        n_cur   = o_q_pop ? i_q_cmd.res : r_cur;
        n_out   = take ? r_cur[sel] : r_out;
        n_out_v = take ? 1'b1 : (i_pop ? 1'b0 : r_out_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_mask  <= n_mask;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    assign o_empty  = !r_out_v;
    assign o_result = r_out;

    a_refill_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> ($countones(r_mask) <= 1))
        else $error("new item loaded while results of the previous one are pending");

    a_last_closes_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_cur[sel].last_out) |-> (rem == '0))
        else $error("result flagged last is not the final one of its item");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_pop) |=> (r_out_v && $stable(r_out)))
        else $error("waiting result changed before it was taken");

endmodule

// ===== tb/sorted_triplet_to_csc_builder_top_tb.sv =====
`timescale 1ns / 1ps
module sorted_triplet_to_csc_builder_top_tb;

    localparam int DW             = stcsc_pkg::DIM_W;
    localparam int TB_MAX_DIM     = stcsc_pkg::DEF_MAX_DIM;
    localparam int TB_MAX_ENTRIES = stcsc_pkg::DEF_MAX_ENTRIES;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 8;

    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [stcsc_pkg::ADDR_W-1:0]    paddr   = '0;
    logic [stcsc_pkg::DATA_W-1:0]    pwdata  = '0;
    logic [stcsc_pkg::DATA_W-1:0]    prdata;
    logic                            pready;
    logic                            push    = 1'b0;
    logic                            full;
    stcsc_pkg::t_in                  i_item  = '0;
    logic                            empty;
    logic                            pop     = 1'b0;
    stcsc_pkg::t_out                 o_result;

    sorted_triplet_to_csc_builder_top #(
        .MAX_DIM    (TB_MAX_DIM),
        .MAX_ENTRIES(TB_MAX_ENTRIES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    stcsc_pkg::t_in  pending_triplets[$];
    stcsc_pkg::t_out predicted_writes[$];
    int unsigned triplets_queued = 0;
    int unsigned triplets_taken  = 0;
    int unsigned writes_checked  = 0;
    int unsigned write_errors    = 0;
    int unsigned kind_seen[3]    = '{0, 0, 0};
    int unsigned settings_used   = 1;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned cycle_count     = 0;

    // Predictor copy of the size registers and of the run state.
    logic [DW-1:0] size_rows = stcsc_pkg::SIZE_RESET;
    logic [DW-1:0] size_cols = stcsc_pkg::SIZE_RESET;
    int unsigned   last_row, last_col, entry_count, cols_filled;
    bit            seen_trip, open_valid, run_dropping;
    logic [15:0]   open_row;
    int unsigned   open_col;
    logic [31:0]   open_value;

    function automatic int unsigned clamp_dim(input logic [DW-1:0] sz);
        return (sz > TB_MAX_DIM) ? TB_MAX_DIM : sz;
    endfunction

    task automatic restart_run();
        last_row     = 0;
        last_col     = 0;
        seen_trip    = 1'b0;
        open_valid   = 1'b0;
        open_row     = '0;
        open_col     = 0;
        open_value   = '0;
        entry_count  = 0;
        cols_filled  = 0;
        run_dropping = 1'b0;
    endtask

    function automatic stcsc_pkg::t_out entry_write();
        stcsc_pkg::t_out w;
        w                = '0;
        w.kind           = stcsc_pkg::KIND_ENTRY;
        w.entry_position = 20'(entry_count - 1);
        w.entry_row      = open_row;
        w.entry_value    = open_value;
        return w;
    endfunction

    function automatic stcsc_pkg::t_out fill_write(input int unsigned first_slot,
                                                   input int unsigned last_slot,
                                                   input int unsigned ptr, input logic is_last);
        stcsc_pkg::t_out w;
        w               = '0;
        w.kind          = stcsc_pkg::KIND_FILL;
        w.range_first   = 17'(first_slot);
        w.range_final   = 17'(last_slot);
        w.pointer_value = 21'(ptr);
        w.last_out      = is_last;
        return w;
    endfunction

    task automatic predict_csc_writes(input stcsc_pkg::t_in trip);
        int unsigned     r, c, rows, cols, lo;
        logic [31:0]     v;
        logic [15:0]     row0;
        longint          sum;
        bit              dup, bad;
        stcsc_pkg::t_err code;
        stcsc_pkg::t_out w;
        r    = trip.row_in;
        c    = trip.col_in;
        v    = trip.value_in;
        row0 = 16'(r - 1);
        dup  = 1'b0;
        bad  = 1'b1;
        code = stcsc_pkg::ERR_ROW_RANGE;
        if (run_dropping) begin
            if (trip.last_in) restart_run();
            return;
        end
        rows = clamp_dim(size_rows);
        cols = clamp_dim(size_cols);
        if (r < 1 || r > rows) begin
            code = stcsc_pkg::ERR_ROW_RANGE;
        end else if (c < 1 || c > cols) begin
            code = stcsc_pkg::ERR_COL_RANGE;
        end else if (seen_trip && c < last_col) begin
            code = stcsc_pkg::ERR_COL_ORDER;
        end else if (seen_trip && c == last_col && r < last_row) begin
            code = stcsc_pkg::ERR_ROW_ORDER;
        end else begin
            bad = 1'b0;
            if (v != 0) begin
                dup = open_valid && c == open_col && row0 == open_row;
                if (!dup && entry_count >= TB_MAX_ENTRIES) begin
                    bad  = 1'b1;
                    code = stcsc_pkg::ERR_OVERFLOW;
                end
            end
        end
        if (bad) begin
            w            = '0;
            w.kind       = stcsc_pkg::KIND_ERROR;
            w.error_code = code;
            w.last_out   = trip.last_in;
            predicted_writes.push_back(w);
            if (trip.last_in) begin
                restart_run();
            end else begin
                run_dropping = 1'b1;
                open_valid   = 1'b0;
            end
            return;
        end
        last_row  = r;
        last_col  = c;
        seen_trip = 1'b1;
        if (v != 0) begin
            if (dup) begin
                sum = longint'($signed(open_value)) + longint'($signed(v));
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                open_value = sum[31:0];
            end else begin
                if (open_valid) predicted_writes.push_back(entry_write());
                if (c > cols_filled) begin
                    predicted_writes.push_back(fill_write(cols_filled, c - 1, entry_count, 1'b0));
                    cols_filled = c;
                end
                open_valid  = 1'b1;
                open_row    = row0;
                open_col    = c;
                open_value  = v;
                entry_count = entry_count + 1;
            end
        end
        if (trip.last_in) begin
            if (open_valid) predicted_writes.push_back(entry_write());
            lo = (cols_filled < cols) ? cols_filled : cols;
            predicted_writes.push_back(fill_write(lo, cols, entry_count, 1'b1));
            restart_run();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            write_errors++;
        end
    endtask

    // Triplet sender: one item in flight on the bus, held while full is high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_csc_writes(i_item);
                triplets_taken++;
            end
            if (!push || !full) begin
                if (pending_triplets.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_item <= pending_triplets.pop_front();
                    push   <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        stcsc_pkg::t_out want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (predicted_writes.size() == 0) begin
                    $error("unexpected result: kind %0d with nothing predicted", o_result.kind);
                    write_errors++;
                end else begin
                    want = predicted_writes.pop_front();
                    check_field("kind", want.kind, o_result.kind);
                    check_field("entry_position", want.entry_position, o_result.entry_position);
                    check_field("entry_row", want.entry_row, o_result.entry_row);
                    check_field("entry_value", want.entry_value, o_result.entry_value);
                    check_field("range_first", want.range_first, o_result.range_first);
                    check_field("range_final", want.range_final, o_result.range_final);
                    check_field("pointer_value", want.pointer_value, o_result.pointer_value);
                    check_field("error_code", want.error_code, o_result.error_code);
                    check_field("last_out", want.last_out, o_result.last_out);
                    if (want.kind <= stcsc_pkg::KIND_ERROR) kind_seen[want.kind]++;
                end
                writes_checked++;
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still predicted",
                     cycle_count, predicted_writes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_triplet(input logic [DW-1:0] r, input logic [DW-1:0] c,
                                 input logic [31:0] v, input logic is_last);
        stcsc_pkg::t_in it;
        it.row_in   = r;
        it.col_in   = c;
        it.value_in = v;
        it.last_in  = is_last;
        pending_triplets.push_back(it);
        triplets_queued++;
    endtask

    // Returns once every item is taken, every result is checked and the pipe has settled.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (triplets_taken != triplets_queued || predicted_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic idx, input logic [DW-1:0] sz);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & 32'hFFFE_0000) | 32'(sz);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == stcsc_pkg::REG_ROWS) size_rows = sz;
        else size_cols = sz;
    endtask

    function automatic int unsigned pick_index(input int unsigned lim);
        case ($urandom_range(0, 2))
            0:       return $urandom_range(1, (lim < 4) ? lim : 4);
            1:       return lim - $urandom_range(0, (lim < 4) ? lim - 1 : 3);
            default: return $urandom_range(1, lim);
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(1, 15) << 16;
            4:       return 32'h0 - ($urandom_range(1, 15) << 16);
            default: return $urandom;
        endcase
    endfunction

    // Random garbage, closed by a last item so that the next matrix starts clean.
    task automatic add_noise(input int n_trip);
        logic [DW-1:0] r, c;
        for (int k = 0; k < n_trip; k++) begin
            r = DW'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 131071));
            c = DW'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 131071));
            queue_triplet(r, c, $urandom, (k == n_trip - 1) || ($urandom_range(0, 3) == 0));
        end
    endtask

    // A sorted matrix, or noise if a size is zero; if broken, one item's row or column is set out of range or lowered.
    task automatic add_matrix(input int n_trip, input bit broken);
        int unsigned rows, cols, r, c, nc, bad_at, br, bc;
        rows = clamp_dim(size_rows);
        cols = clamp_dim(size_cols);
        if (rows == 0 || cols == 0) begin
            add_noise(n_trip);
            return;
        end
        bad_at = broken ? $urandom_range(0, n_trip - 1) : n_trip;
        c      = pick_index(cols);
        r      = pick_index(rows);
        for (int k = 0; k < n_trip; k++) begin
            if (k > 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        // Same coordinate again, so that it can merge with the held entry.
                    end
                    1, 2: begin
                        r = r + $urandom_range(1, 3);
                        if (r > rows) r = rows;
                    end
                    default: begin
                        nc = c + (($urandom_range(0, 4) == 0) ? $urandom_range(1, cols)
                                                               : $urandom_range(1, 3));
                        if (nc > cols) nc = cols;
                        if (nc != c) begin
                            c = nc;
                            r = pick_index(rows);
                        end
                    end
                endcase
            end
            br = r;
            bc = c;
            if (k == bad_at) begin
                case ($urandom_range(0, 3))
                    0:       br = $urandom_range(0, 1) ? 0 : rows + 1;
                    1:       bc = $urandom_range(0, 1) ? 0 : cols + 1;
                    2:       bc = (c > 1) ? c - 1 : 0;
                    default: br = (r > 1) ? r - 1 : 0;
                endcase
            end
            queue_triplet(DW'(br), DW'(bc), pick_value(), k == n_trip - 1);
        end
    endtask

    initial begin
        logic [DW-1:0] rows_sz, cols_sz;
        int unsigned   goal, start_n;
        bit            paused;
        paused = 1'b0;
        restart_run();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed matrix at full size: saturating merges both ways, a merge that
        // cancels to zero, a zero item, column gaps and the largest indices.
        queue_triplet(1, 1, 32'h7FFF_FFFF, 0);
        queue_triplet(1, 1, 32'h7FFF_FFFF, 0);
        queue_triplet(2, 1, 32'h8000_0000, 0);
        queue_triplet(2, 1, 32'h8000_0000, 0);
        queue_triplet(3, 1, 32'h0000_0005, 0);
        queue_triplet(3, 1, 32'hFFFF_FFFB, 0);
        queue_triplet(3, 1, 32'h0, 0);
        queue_triplet(65536, 3, 32'h0001_0000, 0);
        queue_triplet(1, 65536, 32'h0000_0007, 1);
        // A matrix with nothing stored.
        queue_triplet(1, 1, 32'h0, 1);
        // Errors: a dropped tail, then range and order errors, each closing its own matrix.
        queue_triplet(0, 1, 32'h1, 0);
        queue_triplet(5, 5, 32'h5, 0);
        queue_triplet(5, 5, 32'h5, 1);
        queue_triplet(1, 0, 32'h1, 1);
        queue_triplet(1, 2, 32'h1, 0);
        queue_triplet(1, 1, 32'h1, 1);
        queue_triplet(2, 2, 32'h1, 0);
        queue_triplet(1, 2, 32'h1, 1);
        queue_triplet(65537, 1, 32'h1, 1);
        queue_triplet(1, 65537, 32'h1, 1);
        queue_triplet(131071, 131071, 32'hFFFF_FFFF, 1);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    rows_sz = 17'h1FFFF; cols_sz = 17'h1FFFF;
                    send_idle_pct = 0;   recv_stall_pct = 0;
                end
                1: begin
                    rows_sz = 17'd8;     cols_sz = 17'd6;
                    send_idle_pct = 47;  recv_stall_pct = 0;
                end
                2: begin
                    rows_sz = 17'd1;     cols_sz = 17'd1;
                    send_idle_pct = 0;   recv_stall_pct = 47;
                end
                3: begin
                    rows_sz = stcsc_pkg::SIZE_RESET; cols_sz = 17'd3;
                    send_idle_pct = 30;  recv_stall_pct = 30;
                end
                4: begin
                    rows_sz = 17'd0;     cols_sz = 17'd0;
                    send_idle_pct = 0;   recv_stall_pct = 0;
                end
                default: begin
                    rows_sz = 17'd300;   cols_sz = stcsc_pkg::SIZE_RESET;
                    send_idle_pct = 30;  recv_stall_pct = 30;
                end
            endcase
            write_size(stcsc_pkg::REG_ROWS, rows_sz);
            write_size(stcsc_pkg::REG_COLS, cols_sz);
            settings_used++;
            goal    = (p == 4) ? 8 : 20;
            start_n = triplets_queued;
            // One long matrix with many distinct entries at the largest size.
            if (p == 0) add_matrix(26, 0);
            while (triplets_queued - start_n < goal) begin
                case ($urandom_range(0, 9))
                    0:       add_noise($urandom_range(1, 4));
                    1, 2:    add_matrix($urandom_range(2, 6), 1);
                    3:       add_matrix($urandom_range(18, 26), 0);
                    default: add_matrix($urandom_range(1, 6), 0);
                endcase
                if (p == 2 && !paused) begin
                    // Let the block run completely dry in the middle of a phase.
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        $display("Sent %0d triplets under %0d size settings and checked %0d results",
                 triplets_taken, settings_used, writes_checked);
        $display("(%0d entries, %0d pointer fills, %0d errors).",
                 kind_seen[stcsc_pkg::KIND_ENTRY], kind_seen[stcsc_pkg::KIND_FILL],
                 kind_seen[stcsc_pkg::KIND_ERROR]);
        if (write_errors == 0 && predicted_writes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
